// ===== design/buck_boost_pi_duty_controller_defines.svh =====
// Assertion macros shared by the duty controller RTL.
`ifndef BUCK_BOOST_PI_DUTY_CONTROLLER_DEFINES_SVH
`define BUCK_BOOST_PI_DUTY_CONTROLLER_DEFINES_SVH

// Same-cycle implication, checked on i_clk and disabled while in reset.
`define BBPI_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on i_clk and disabled while in reset.
`define BBPI_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/bbpi_pkg.sv =====
// Shared types and constants of the buck/buck-boost duty controller.
package bbpi_pkg;

    localparam int HYST_BAND_DEF   = 50;
    localparam int INTEG_WIDTH_DEF = 24;
    localparam int MODE_CENTER     = 2800;

    localparam int DEN_W  = 29;
    localparam int PROD_W = 28;
    localparam int CFG_W  = 23;

    localparam logic [15:0]      BUCK_FIRST = 16'd1000;
    localparam logic [15:0]      BB_HIGH    = 16'd32000;
    // Period counts times the feedforward volts; the full dividend is this times 2^16.
    localparam logic [DEN_W-1:0] FF_NUM_HI  = 29'd1088000;
    // Twenty volts in the Q16 scale of the product.
    localparam logic [DEN_W-1:0] BB_OFFSET  = 29'd1310720;

    localparam logic [2:0] CFG_TARGET   = 3'd0;
    localparam logic [2:0] CFG_KP       = 3'd1;
    localparam logic [2:0] CFG_KI       = 3'd2;
    localparam logic [2:0] CFG_ILIM     = 3'd3;
    localparam logic [2:0] CFG_BHIGH    = 3'd4;
    localparam logic [2:0] CFG_LOW      = 3'd5;
    localparam logic [2:0] CFG_VSCALE   = 3'd6;
    localparam logic [2:0] CFG_LOOP_EN  = 3'd7;

    typedef struct packed {
        logic [11:0] vin_sample;
        logic [11:0] vout_sample;
    } t_in_req;

    typedef struct packed {
        logic [15:0] compare_first;
        logic [15:0] compare_second;
        logic        boost_mode;
    } t_out_req;

    typedef struct packed {
        logic        done;
        logic [15:0] quot;
    } t_div_stat;

endpackage

// ===== design/bbpi_div.sv =====
// Bit-serial restoring divider for the feedforward duty, saturating at 16 bits.
module bbpi_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [bbpi_pkg::DEN_W-1:0]   i_divisor,
    output bbpi_pkg::t_div_stat          o_stat
);

    logic                         r_busy;
    logic                         r_done;
    logic [3:0]                   r_cnt;
    logic [bbpi_pkg::DEN_W-1:0]   r_rem;
    logic [bbpi_pkg::DEN_W-1:0]   r_den;
    logic [15:0]                  r_quot;
    logic                         r_sat;

    logic [bbpi_pkg::DEN_W:0]     w_trial;
    logic [bbpi_pkg::DEN_W:0]     w_diff;
    logic                         w_ge;

    always_comb begin
        w_trial = {r_rem, 1'b0};
        w_diff  = w_trial - {1'b0, r_den};
        w_ge    = (w_trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 4'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 4'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // The remainder stays below the divisor, so one compare per quotient bit.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= bbpi_pkg::FF_NUM_HI;
            r_den  <= i_divisor;
            r_sat  <= (bbpi_pkg::FF_NUM_HI >= i_divisor);
            r_quot <= 16'd0;
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_diff[bbpi_pkg::DEN_W-1:0] : w_trial[bbpi_pkg::DEN_W-1:0];
            r_quot <= {r_quot[14:0], w_ge};
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.quot = r_sat ? 16'hFFFF : r_quot;

endmodule

// ===== design/buck_boost_pi_duty_controller.sv =====
// Top level of the buck/buck-boost PI duty controller with feedforward.
// One request carries an input and output voltage sample pair. The block first picks
// buck or buck-boost mode with hysteresis around input code 2800, then runs the
// scaled-input product and the PI sum bit-serially, feeds the product into a
// 16-step serial restoring divider for the feedforward duty and, with the loop
// enabled, adds the PI correction and clamps. A request is accepted only while the
// controller is idle; it then passes through the integrator update, the serial
// multiply, the divider load, the divide steps and their done flag, the correction
// and the clamp, which waits until the output register is free before it loads the
// result. The next request can be accepted in the cycle after the result is loaded.
// The result sits in an output register, so the next request is accepted while it
// waits to be taken. Configuration writes take effect at once and are meant for idle periods.
`include "buck_boost_pi_duty_controller_defines.svh"
module buck_boost_pi_duty_controller #(
    parameter int HYST_BAND   = bbpi_pkg::HYST_BAND_DEF,
    parameter int INTEG_WIDTH = bbpi_pkg::INTEG_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  bbpi_pkg::t_in_req           i_in_req,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output bbpi_pkg::t_out_req          o_out_req,
    input  logic                        i_cfg_we,
    input  logic [2:0]                  i_cfg_idx,
    input  logic [bbpi_pkg::CFG_W-1:0]  i_cfg_data
);

    // Integrator sum, PI accumulator and correction widths.
    localparam int BW = INTEG_WIDTH + 1;
    localparam int SW = INTEG_WIDTH + 18;
    localparam int CW = SW - 10;
    localparam int TW = CW + 1;

    localparam logic [11:0] MODE_LO = 12'(bbpi_pkg::MODE_CENTER - HYST_BAND);
    localparam logic [11:0] MODE_HI = 12'(bbpi_pkg::MODE_CENTER + HYST_BAND);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_INTEG = 3'd1;
    localparam logic [2:0] S_SER   = 3'd2;
    localparam logic [2:0] S_DLOAD = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_CORR  = 3'd5;
    localparam logic [2:0] S_CLAMP = 3'd6;

    // Configuration registers.
    logic [11:0] r_target;
    logic [15:0] r_kp;
    logic [15:0] r_ki;
    logic [22:0] r_ilim;
    logic [15:0] r_bhigh;
    logic [15:0] r_low;
    logic [15:0] r_vscale;
    logic        r_loop_en;

    // Control and state.
    logic [2:0]  r_state;
    logic [3:0]  r_cnt;
    logic        r_mode;
    logic signed [INTEG_WIDTH-1:0] r_buck_int;
    logic signed [INTEG_WIDTH-1:0] r_boost_int;
    logic        r_out_valid;

    // Per-request working registers.
    logic [11:0]                  r_vin;
    logic signed [12:0]           r_err;
    logic signed [BW-1:0]         r_acc;
    logic [bbpi_pkg::PROD_W-1:0]  r_prod;
    logic signed [SW-1:0]         r_pi;
    logic [15:0]                  r_ff;
    logic signed [CW-1:0]         r_corr;
    bbpi_pkg::t_out_req           r_out;

    logic                         w_in_acc;
    logic                         w_mode_next;
    logic signed [12:0]           w_err;
    logic signed [INTEG_WIDTH-1:0] w_integ_cur;
    logic signed [BW-1:0]         w_isum;
    logic [32:0]                  w_cap;
    logic [32:0]                  w_lim;
    logic [32:0]                  w_bound33;
    logic signed [BW-1:0]         w_bound;
    logic signed [BW-1:0]         w_acc_sat;
    logic [3:0]                   w_bit;
    logic signed [SW-1:0]         w_term;
    logic [bbpi_pkg::PROD_W-1:0]  w_pp;
    logic [bbpi_pkg::DEN_W-1:0]   w_divisor;
    logic signed [SW-1:0]         w_round;
    logic signed [SW-1:0]         w_qd;
    logic signed [SW-1:0]         w_corr_full;
    logic signed [TW-1:0]         w_total;
    logic [15:0]                  w_high;
    logic signed [TW-1:0]         w_high_t;
    logic signed [TW-1:0]         w_low_t;
    logic [15:0]                  w_duty;
    logic                         w_out_load;
    bbpi_pkg::t_div_stat          w_div;

    assign w_in_acc    = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_out_load  = (r_state == S_CLAMP) && (!r_out_valid || !i_out_stall);

    // Hysteresis: low input picks buck-boost, high input picks buck, the band keeps the mode.
    always_comb begin
        if (i_in_req.vin_sample < MODE_LO) begin
            w_mode_next = 1'b1;
        end else if (i_in_req.vin_sample > MODE_HI) begin
            w_mode_next = 1'b0;
        end else begin
            w_mode_next = r_mode;
        end
        w_err = $signed({1'b0, r_target}) - $signed({1'b0, i_in_req.vout_sample});
    end

    // Integrator update with a symmetric bound of min(limit, largest positive value).
    always_comb begin
        w_integ_cur = r_mode ? r_boost_int : r_buck_int;
        w_isum      = BW'(w_integ_cur) + BW'(r_err);
        w_cap       = 33'((64'd1 << (INTEG_WIDTH - 1)) - 64'd1);
        w_lim       = 33'(r_ilim);
        w_bound33   = (w_lim < w_cap) ? w_lim : w_cap;
        w_bound     = signed'(w_bound33[BW-1:0]);
        if (w_isum > w_bound) begin
            w_acc_sat = w_bound;
        end else if (w_isum < -w_bound) begin
            w_acc_sat = -w_bound;
        end else begin
            w_acc_sat = w_isum;
        end
    end

    // Serial step, gain and scale bits taken most significant first.
    always_comb begin
        w_bit  = ~r_cnt;
        w_term = (r_kp[w_bit] ? SW'(r_err) : SW'(0)) + (r_ki[w_bit] ? SW'(r_acc) : SW'(0));
        w_pp   = r_vscale[w_bit] ? bbpi_pkg::PROD_W'(r_vin) : '0;
        w_divisor = r_mode ? ({1'b0, r_prod} + bbpi_pkg::BB_OFFSET) : {1'b0, r_prod};
    end

    // Division by 256 toward zero, then a floor shift by two, folded into one rounded shift.
    always_comb begin
        w_round     = r_pi[SW-1] ? SW'(255) : SW'(0);
        w_qd        = r_pi + w_round;
        w_corr_full = w_qd >>> 10;
    end

    // Clamp of feedforward plus correction in full width; loop off gives bare feedforward.
    always_comb begin
        w_high   = r_mode ? bbpi_pkg::BB_HIGH : r_bhigh;
        w_high_t = signed'(TW'({1'b0, w_high}));
        w_low_t  = signed'(TW'({1'b0, r_low}));
        w_total  = signed'(TW'({1'b0, r_ff})) + TW'(r_corr);
        if (!r_loop_en) begin
            w_duty = r_ff;
        end else if (w_total > w_high_t) begin
            w_duty = w_high;
        end else if (w_total < w_low_t) begin
            w_duty = r_low;
        end else begin
            w_duty = w_total[15:0];
        end
    end

    bbpi_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_state == S_DLOAD),
        .i_divisor (w_divisor),
        .o_stat    (w_div)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target  <= 12'd0;
            r_kp      <= 16'd0;
            r_ki      <= 16'd0;
            r_ilim    <= 23'd8388607;
            r_bhigh   <= 16'd54400;
            r_low     <= 16'd0;
            r_vscale  <= 16'd655;
            r_loop_en <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bbpi_pkg::CFG_TARGET:  r_target  <= i_cfg_data[11:0];
                bbpi_pkg::CFG_KP:      r_kp      <= i_cfg_data[15:0];
                bbpi_pkg::CFG_KI:      r_ki      <= i_cfg_data[15:0];
                bbpi_pkg::CFG_ILIM:    r_ilim    <= i_cfg_data[22:0];
                bbpi_pkg::CFG_BHIGH:   r_bhigh   <= i_cfg_data[15:0];
                bbpi_pkg::CFG_LOW:     r_low     <= i_cfg_data[15:0];
                bbpi_pkg::CFG_VSCALE:  r_vscale  <= i_cfg_data[15:0];
                bbpi_pkg::CFG_LOOP_EN: r_loop_en <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= 4'd0;
            r_mode      <= 1'b0;
            r_buck_int  <= '0;
            r_boost_int <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_mode  <= w_mode_next;
                        r_cnt   <= 4'd0;
                        r_state <= S_INTEG;
                    end
                end
                S_INTEG: begin
                    // Only the active mode's integrator moves, and only with the loop closed.
                    if (r_loop_en) begin
                        if (r_mode) begin
                            r_boost_int <= w_acc_sat[INTEG_WIDTH-1:0];
                        end else begin
                            r_buck_int <= w_acc_sat[INTEG_WIDTH-1:0];
                        end
                    end
                    r_state <= S_SER;
                end
                S_SER: begin
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'd15) begin
                        r_state <= S_DLOAD;
                    end
                end
                S_DLOAD: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_div.done) begin
                        r_state <= S_CORR;
                    end
                end
                S_CORR: begin
                    r_state <= S_CLAMP;
                end
                S_CLAMP: begin
                    if (w_out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_vin  <= i_in_req.vin_sample;
            r_err  <= w_err;
            r_prod <= '0;
            r_pi   <= '0;
        end
        if (r_state == S_INTEG) begin
            r_acc <= w_acc_sat;
        end
        if (r_state == S_SER) begin
            r_prod <= {r_prod[bbpi_pkg::PROD_W-2:0], 1'b0} + w_pp;
            r_pi   <= (r_pi <<< 1) + w_term;
        end
        if (r_state == S_DIV && w_div.done) begin
            r_ff <= w_div.quot;
        end
        if (r_state == S_CORR) begin
            r_corr <= w_corr_full[CW-1:0];
        end
        if (w_out_load) begin
            r_out.compare_first  <= r_mode ? w_duty : bbpi_pkg::BUCK_FIRST;
            r_out.compare_second <= w_duty;
            r_out.boost_mode     <= r_mode;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

    `BBPI_NEXT(a_accept_starts, i_in_valid && !o_in_stall,
        r_state == S_INTEG, "accept did not start")
    `BBPI_IMPLIES(a_div_done_state, w_div.done,
        r_state == S_DIV, "divider done out of sequence")
    `BBPI_IMPLIES(a_boost_same, r_out_valid && o_out_req.boost_mode,
        o_out_req.compare_first == o_out_req.compare_second, "boost compares differ")
    `BBPI_IMPLIES(a_buck_first, r_out_valid && !o_out_req.boost_mode,
        o_out_req.compare_first == bbpi_pkg::BUCK_FIRST, "buck first compare wrong")

endmodule

// ===== dv/tb_buck_boost_pi_duty_controller.sv =====
// Self-checking testbench of the buck/buck-boost PI duty controller.
`timescale 1ns / 100ps

module tb_buck_boost_pi_duty_controller;

    localparam int LATENCY_WAIT = 60;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int CFG_WIDTH = bbpi_pkg::CFG_W;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_in_valid;
    logic                       o_in_stall;
    bbpi_pkg::t_in_req          i_in_req;
    logic                       o_out_valid;
    logic                       i_out_stall;
    bbpi_pkg::t_out_req         o_out_req;
    logic                       i_cfg_we;
    logic [2:0]                 i_cfg_idx;
    logic [CFG_WIDTH-1:0]       i_cfg_data;

    buck_boost_pi_duty_controller dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_req   (o_out_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    // Shadow copy of the configuration registers and the controller state.
    logic [11:0] sh_target;
    logic [15:0] sh_kp, sh_ki, sh_bhigh, sh_low, sh_vscale;
    logic [22:0] sh_ilim;
    logic        sh_loop_en;
    logic        sh_mode;
    longint      sh_buck_integ, sh_boost_integ;

    bbpi_pkg::t_out_req duty_expect_q[$];
    int       mismatch_cnt;
    int       compared_cnt;
    int       idle_cycles;
    bit       timed_out;
    bit       idling_on;
    int       boost_seen, buck_seen;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Saturating integrator step followed by the PI correction. The division
    // truncates toward zero, while the final shift by two rounds toward minus
    // infinity.
    function automatic longint pi_step(ref longint integ, input longint err);
        longint bound, acc, total, quo;
        bound = (sh_ilim < 23'h7FFFFF) ? longint'(sh_ilim) : longint'(23'h7FFFFF);
        acc = integ + err;
        if (acc > bound) acc = bound;
        if (acc < -bound) acc = -bound;
        integ = acc;
        total = longint'(sh_kp) * err + longint'(sh_ki) * acc;
        quo = (total >= 0) ? total / 256 : -((-total) / 256);
        return quo >>> 2;
    endfunction

    // Predicts the compare values for one sample pair and updates the state.
    function automatic bbpi_pkg::t_out_req predict_duty(bbpi_pkg::t_in_req req);
        bbpi_pkg::t_out_req res;
        longint unsigned num, prod, ff;
        longint high, total, err;
        logic [15:0] duty;
        num = 64'd54400 * 64'd20 * 64'd65536;
        prod = longint'(req.vin_sample) * longint'(sh_vscale);
        if (req.vin_sample < bbpi_pkg::MODE_CENTER - bbpi_pkg::HYST_BAND_DEF) sh_mode = 1'b1;
        else if (req.vin_sample > bbpi_pkg::MODE_CENTER + bbpi_pkg::HYST_BAND_DEF)
            sh_mode = 1'b0;
        if (!sh_mode) begin
            ff = (prod == 0) ? 64'd65535 : num / prod;
            if (ff > 65535) ff = 64'd65535;
            high = longint'(sh_bhigh);
        end else begin
            ff = num / (prod + 64'd20 * 64'd65536);
            high = longint'(bbpi_pkg::BB_HIGH);
        end
        if (sh_loop_en) begin
            err = longint'(sh_target) - longint'(req.vout_sample);
            if (sh_mode) total = longint'(ff) + pi_step(sh_boost_integ, err);
            else total = longint'(ff) + pi_step(sh_buck_integ, err);
            if (total > high) total = high;
            else if (total < longint'(sh_low)) total = longint'(sh_low);
            duty = total[15:0];
        end else begin
            duty = ff[15:0];
        end
        res.compare_first = sh_mode ? duty : bbpi_pkg::BUCK_FIRST;
        res.compare_second = duty;
        res.boost_mode = sh_mode;
        return res;
    endfunction

    // Writes one register; only called while the controller is idle.
    task automatic write_reg(input logic [2:0] idx, input logic [CFG_WIDTH-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            bbpi_pkg::CFG_TARGET:  sh_target = val[11:0];
            bbpi_pkg::CFG_KP:      sh_kp = val[15:0];
            bbpi_pkg::CFG_KI:      sh_ki = val[15:0];
            bbpi_pkg::CFG_ILIM:    sh_ilim = val[22:0];
            bbpi_pkg::CFG_BHIGH:   sh_bhigh = val[15:0];
            bbpi_pkg::CFG_LOW:     sh_low = val[15:0];
            bbpi_pkg::CFG_VSCALE:  sh_vscale = val[15:0];
            bbpi_pkg::CFG_LOOP_EN: sh_loop_en = val[0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic write_all(input logic [11:0] target, input logic [15:0] kp,
                             input logic [15:0] ki, input logic [22:0] ilim,
                             input logic [15:0] bhigh, input logic [15:0] low,
                             input logic [15:0] vscale, input logic loop_en);
        write_reg(bbpi_pkg::CFG_TARGET, CFG_WIDTH'(target));
        write_reg(bbpi_pkg::CFG_KP, CFG_WIDTH'(kp));
        write_reg(bbpi_pkg::CFG_KI, CFG_WIDTH'(ki));
        write_reg(bbpi_pkg::CFG_ILIM, CFG_WIDTH'(ilim));
        write_reg(bbpi_pkg::CFG_BHIGH, CFG_WIDTH'(bhigh));
        write_reg(bbpi_pkg::CFG_LOW, CFG_WIDTH'(low));
        write_reg(bbpi_pkg::CFG_VSCALE, CFG_WIDTH'(vscale));
        write_reg(bbpi_pkg::CFG_LOOP_EN, CFG_WIDTH'(loop_en));
    endtask

    // Sends one sample pair request, with an optional random gap before it.
    // The expectation is queued at the accepting edge, so the order matches
    // the order in which the block sees the requests. Valid stays high after
    // the accept; a gap before the next request or the drain takes it down.
    task automatic send_sample(input logic [11:0] vin, input logic [11:0] vout);
        bbpi_pkg::t_in_req req;
        req.vin_sample = vin;
        req.vout_sample = vout;
        if (idling_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req <= req;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        duty_expect_q.push_back(predict_duty(req));
    endtask

    // Waits until every expected result has been taken, then lets the block settle.
    task automatic drain;
        i_in_valid <= 1'b0;
        while (duty_expect_q.size() != 0 && !timed_out) @(posedge i_clk);
        repeat (LATENCY_WAIT) @(posedge i_clk);
    endtask

    // Sends a sample pair mid-sequence: input near the mode threshold, outside the
    // band or anywhere; output mostly near the setpoint, sometimes anywhere.
    task automatic send_random_sample;
        logic [11:0] vin, vout;
        case ($urandom_range(0, 3))
            0: vin = 12'($urandom_range(2700, 2900));
            1: vin = 12'($urandom_range(0, 4095));
            2: vin = 12'($urandom_range(0, 2749));
            default: vin = 12'($urandom_range(2851, 4095));
        endcase
        if ($urandom_range(0, 2) == 0) vout = 12'($urandom_range(0, 4095));
        else vout = (sh_target > 40 && sh_target < 4055) ?
                    12'(sh_target + $urandom_range(0, 80) - 40) :
                    12'($urandom_range(0, 4095));
        send_sample(vin, vout);
    endtask

    // Result side: random stall bursts and a field-by-field comparison.
    initial begin
        bbpi_pkg::t_out_req exp_res;
        i_out_stall = 1'b0;
        mismatch_cnt = 0;
        compared_cnt = 0;
        boost_seen = 0;
        buck_seen = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                if (duty_expect_q.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("unexpected result %p", o_out_req);
                end else begin
                    exp_res = duty_expect_q.pop_front();
                    compared_cnt++;
                    if (exp_res.boost_mode) boost_seen++;
                    else buck_seen++;
                    if (exp_res.compare_first !== o_out_req.compare_first ||
                        exp_res.compare_second !== o_out_req.compare_second ||
                        exp_res.boost_mode !== o_out_req.boost_mode) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display("mismatch: expected %0d/%0d/%0b got %0d/%0d/%0b",
                                     exp_res.compare_first, exp_res.compare_second,
                                     exp_res.boost_mode, o_out_req.compare_first,
                                     o_out_req.compare_second, o_out_req.boost_mode);
                    end
                end
            end
            // Stall bursts; a stalled result stays put, so a change of stall
            // is always safe here.
            if (idling_on && !i_out_stall && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: counts cycles with no accepted request on either side or cfg write.
    initial begin
        idle_cycles = 0;
        timed_out = 1'b0;
        forever begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we)
                idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                timed_out = 1'b1;
                $display("[buck_boost_pi_duty_controller] ERROR");
                $finish;
            end
        end
    end

    // Feedforward only, at the reset configuration: zero input, the extremes
    // of both samples and both sides of the hysteresis band.
    task automatic test_feedforward;
        send_sample(12'd0, 12'd0);
        send_sample(12'd4095, 12'd4095);
        send_sample(12'd2851, 12'd0);
        send_sample(12'd2850, 12'd1);
        send_sample(12'd2749, 12'd2);
        send_sample(12'd2750, 12'd3);
        send_sample(12'd2851, 12'hAAA);
        send_sample(12'd0, 12'h555);
        send_sample(12'd4095, 12'd0);
        drain();
    endtask

    // Closed loop with large gains: saturates the integrators and hits both clamps,
    // then lowers the limit so a stored integral is pulled back.
    task automatic test_closed_loop_extremes;
        write_all(12'd4095, 16'hFFFF, 16'hFFFF, 23'h7FFFFF, 16'd54400, 16'd0,
                  16'hFFFF, 1'b1);
        repeat (3) send_sample(12'd4095, 12'd0);
        repeat (3) send_sample(12'd100, 12'd0);
        drain();
        write_reg(bbpi_pkg::CFG_TARGET, 23'd0);
        repeat (3) send_sample(12'd4095, 12'd4095);
        drain();
        write_reg(bbpi_pkg::CFG_ILIM, 23'd10);
        send_sample(12'd4000, 12'd0);
        send_sample(12'd1, 12'd4095);
        drain();
        // Low limit above the high limit and a tiny scale.
        write_reg(bbpi_pkg::CFG_LOW, 23'd54400);
        write_reg(bbpi_pkg::CFG_BHIGH, 23'd0);
        write_reg(bbpi_pkg::CFG_VSCALE, 23'd1);
        send_sample(12'd4095, 12'd0);
        send_sample(12'd0, 12'd4095);
        drain();
        write_reg(bbpi_pkg::CFG_ILIM, 23'd0);
        send_sample(12'd3000, 12'd0);
        drain();
    endtask

    // Random configuration phases, each followed by well-formed sample sequences.
    task automatic test_random_phases(input int n_items);
        int sent;
        sent = 0;
        while (sent < n_items && !timed_out) begin
            write_all(12'($urandom_range(0, 4095)), 16'($urandom_range(0, 65535)),
                      16'($urandom_range(0, 1) ? $urandom_range(0, 512) :
                          $urandom_range(0, 65535)),
                      23'($urandom_range(0, 1) ? $urandom_range(0, 5000) :
                          $urandom_range(0, 8388607)),
                      16'($urandom_range(0, 54400)), 16'($urandom_range(0, 54400)),
                      16'($urandom_range(1, 65535)), ($urandom_range(0, 3) != 0));
            repeat (40) begin
                send_random_sample();
                sent++;
            end
            drain();
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_req = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = bbpi_pkg::CFG_TARGET;
        i_cfg_data = '0;
        idling_on = 1'b1;
        sh_target = '0; sh_kp = '0; sh_ki = '0; sh_ilim = 23'h7FFFFF;
        sh_bhigh = 16'd54400; sh_low = '0; sh_vscale = 16'd655; sh_loop_en = 1'b0;
        sh_mode = 1'b0; sh_buck_integ = 0; sh_boost_integ = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_feedforward();
        test_closed_loop_extremes();
        test_random_phases(320);
        // Final stretch with no idling on either side.
        idling_on = 1'b0;
        test_random_phases(80);
        drain();

        $display("Checked %0d results (%0d buck, %0d buck-boost) over random settings.",
                 compared_cnt, buck_seen, boost_seen);
        if (mismatch_cnt == 0 && duty_expect_q.size() == 0) begin
            $display("[buck_boost_pi_duty_controller] OK");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatch_cnt,
                     duty_expect_q.size());
            $display("[buck_boost_pi_duty_controller] ERROR");
        end
        $finish;
    end

endmodule
